@@ rtl/tcfo_pkg.sv @@
// Shared types and codes for the two-class FIFO with oldest-first dequeue.
`timescale 1ns / 1ps

package tcfo_pkg;

	localparam int unsigned KIND_W   = 3;
	localparam int unsigned OUT_ID_W = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned STAMP_W  = 8;

	// Operation codes on the kind port
	localparam logic [KIND_W-1:0] KIND_ENQ_DOG = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ENQ_CAT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DEQ_ANY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DEQ_DOG = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DEQ_CAT = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Class codes
	localparam logic CLS_DOG = 1'b0;
	localparam logic CLS_CAT = 1'b1;

	typedef enum logic [2:0] {
		OP_ENQ_DOG,
		OP_ENQ_CAT,
		OP_DEQ_ANY,
		OP_DEQ_DOG,
		OP_DEQ_CAT,
		OP_BAD
	} op_t;

	// Classified command handed from the front to the back
	typedef struct packed {
		op_t                 op;
		logic [OUT_ID_W-1:0] id;
	} cmd_t;

	// One result word
	typedef struct packed {
		logic [OUT_ID_W-1:0] id;
		logic                cls;
		logic [STATUS_W-1:0] status;
	} result_t;

	// Occupancy flags of one class queue
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_flags_t;

	typedef enum logic {
		BK_FETCH,
		BK_EXEC
	} bk_state_t;

endpackage

@@ rtl/tcfo_front.sv @@
// Front end: accept input words, decode the operation, queue commands for the back end.
`timescale 1ns / 1ps

module tcfo_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tcfo_pkg::KIND_W-1:0]   kind,
	input  logic [tcfo_pkg::OUT_ID_W-1:0] animal_id,
	output logic                          cmd_valid,
	output tcfo_pkg::cmd_t                cmd,
	input  logic                          cmd_pop
);

	localparam int unsigned CQ_DEPTH = 2;

	tcfo_pkg::cmd_t cq_q [CQ_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	tcfo_pkg::op_t  op_dec;
	logic           acc;
	logic           take;

	always_comb begin
		unique case (kind)
			tcfo_pkg::KIND_ENQ_DOG: op_dec = tcfo_pkg::OP_ENQ_DOG;
			tcfo_pkg::KIND_ENQ_CAT: op_dec = tcfo_pkg::OP_ENQ_CAT;
			tcfo_pkg::KIND_DEQ_ANY: op_dec = tcfo_pkg::OP_DEQ_ANY;
			tcfo_pkg::KIND_DEQ_DOG: op_dec = tcfo_pkg::OP_DEQ_DOG;
			tcfo_pkg::KIND_DEQ_CAT: op_dec = tcfo_pkg::OP_DEQ_CAT;
			default:                op_dec = tcfo_pkg::OP_BAD;
		endcase
	end

	assign full      = (cnt_q == 2'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cq_q[rd_ptr_q];
	assign acc       = push && !full;
	assign take      = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (acc) begin
			cq_q[wr_ptr_q].op <= op_dec;
			cq_q[wr_ptr_q].id <= animal_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (acc)
				wr_ptr_q <= ~wr_ptr_q;
			if (take)
				rd_ptr_q <= ~rd_ptr_q;
			case ({acc, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/tcfo_class_fifo.sv @@
// Circular queue for one class: identifier and arrival stamp memory with registered head read.
`timescale 1ns / 1ps

module tcfo_class_fifo #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned ID_W  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ID_W-1:0]              wr_id,
	input  logic [tcfo_pkg::STAMP_W-1:0] wr_stamp,
	input  logic                         rd_en,
	input  logic                         pop,
	output logic [ID_W-1:0]              head_id,
	output logic [tcfo_pkg::STAMP_W-1:0] head_stamp,
	output tcfo_pkg::fifo_flags_t        flags
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [ID_W-1:0]              id_mem    [DEPTH];
	logic [tcfo_pkg::STAMP_W-1:0] stamp_mem [DEPTH];
	logic [PTR_W-1:0]             head_q;
	logic [PTR_W-1:0]             tail_q;
	logic [CNT_W-1:0]             count_q;

	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[tail_q]    <= wr_id;
			stamp_mem[tail_q] <= wr_stamp;
		end
		if (rd_en) begin
			head_id    <= id_mem[head_q];
			head_stamp <= stamp_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en)
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
			if (pop)
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
			case ({wr_en, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/tcfo_back.sv @@
// Back end: execute commands against the two class queues and buffer the result words.
`timescale 1ns / 1ps

module tcfo_back #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_WIDTH    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  tcfo_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              res_empty,
	output tcfo_pkg::result_t res,
	input  logic              res_pop
);

	localparam int unsigned RES_DEPTH = 2;

	tcfo_pkg::bk_state_t          state_q;
	tcfo_pkg::bk_state_t          state_d;
	tcfo_pkg::cmd_t               cur_q;
	logic [tcfo_pkg::STAMP_W-1:0] arrival_q;

	tcfo_pkg::result_t res_q [RES_DEPTH];
	logic              res_wr_ptr_q;
	logic              res_rd_ptr_q;
	logic [1:0]        res_cnt_q;
	logic              res_wr;
	logic              res_take;
	tcfo_pkg::result_t res_d;

	logic                         rd_en;
	logic                         dog_push;
	logic                         cat_push;
	logic                         dog_pop;
	logic                         cat_pop;
	logic [ID_WIDTH-1:0]          wr_id;
	logic [ID_WIDTH-1:0]          dog_head_id;
	logic [ID_WIDTH-1:0]          cat_head_id;
	logic [tcfo_pkg::STAMP_W-1:0] dog_head_stamp;
	logic [tcfo_pkg::STAMP_W-1:0] cat_head_stamp;
	logic [tcfo_pkg::STAMP_W-1:0] stamp_diff;
	tcfo_pkg::fifo_flags_t        dog_flags;
	tcfo_pkg::fifo_flags_t        cat_flags;
	logic                         any_cls;

	assign wr_id = ID_WIDTH'(cur_q.id);

	tcfo_class_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.ID_W  (ID_WIDTH)
	) u_dog_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (dog_push),
		.wr_id      (wr_id),
		.wr_stamp   (arrival_q),
		.rd_en      (rd_en),
		.pop        (dog_pop),
		.head_id    (dog_head_id),
		.head_stamp (dog_head_stamp),
		.flags      (dog_flags)
	);

	tcfo_class_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.ID_W  (ID_WIDTH)
	) u_cat_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cat_push),
		.wr_id      (wr_id),
		.wr_stamp   (arrival_q),
		.rd_en      (rd_en),
		.pop        (cat_pop),
		.head_id    (cat_head_id),
		.head_stamp (cat_head_stamp),
		.flags      (cat_flags)
	);

	// Oldest head wins: modular stamp distance below half range means the dog came first
	assign stamp_diff = cat_head_stamp - dog_head_stamp;

	always_comb begin
		if (cat_flags.empty)
			any_cls = tcfo_pkg::CLS_DOG;
		else if (dog_flags.empty)
			any_cls = tcfo_pkg::CLS_CAT;
		else
			any_cls = stamp_diff[tcfo_pkg::STAMP_W-1] ? tcfo_pkg::CLS_CAT : tcfo_pkg::CLS_DOG;
	end

	always_comb begin
		state_d      = state_q;
		cmd_pop      = 1'b0;
		rd_en        = 1'b0;
		dog_push     = 1'b0;
		cat_push     = 1'b0;
		dog_pop      = 1'b0;
		cat_pop      = 1'b0;
		res_wr       = 1'b0;
		res_d.id     = '0;
		res_d.cls    = tcfo_pkg::CLS_DOG;
		res_d.status = tcfo_pkg::ST_EMPTY;
		unique case (state_q)
			tcfo_pkg::BK_FETCH: begin
				// Latch a command and read both heads once a result slot is free
				if (cmd_valid && (res_cnt_q != 2'(RES_DEPTH))) begin
					cmd_pop = 1'b1;
					rd_en   = 1'b1;
					state_d = tcfo_pkg::BK_EXEC;
				end
			end
			tcfo_pkg::BK_EXEC: begin
				res_wr  = 1'b1;
				state_d = tcfo_pkg::BK_FETCH;
				unique case (cur_q.op)
					tcfo_pkg::OP_ENQ_DOG: begin
						res_d.cls = tcfo_pkg::CLS_DOG;
						if (dog_flags.full) begin
							res_d.status = tcfo_pkg::ST_FULL;
						end else begin
							dog_push     = 1'b1;
							res_d.status = tcfo_pkg::ST_OK;
						end
					end
					tcfo_pkg::OP_ENQ_CAT: begin
						res_d.cls = tcfo_pkg::CLS_CAT;
						if (cat_flags.full) begin
							res_d.status = tcfo_pkg::ST_FULL;
						end else begin
							cat_push     = 1'b1;
							res_d.status = tcfo_pkg::ST_OK;
						end
					end
					tcfo_pkg::OP_DEQ_ANY: begin
						res_d.cls = any_cls;
						if (any_cls == tcfo_pkg::CLS_DOG) begin
							if (!dog_flags.empty) begin
								dog_pop      = 1'b1;
								res_d.id     = tcfo_pkg::OUT_ID_W'(dog_head_id);
								res_d.status = tcfo_pkg::ST_OK;
							end
						end else begin
							cat_pop      = 1'b1;
							res_d.id     = tcfo_pkg::OUT_ID_W'(cat_head_id);
							res_d.status = tcfo_pkg::ST_OK;
						end
					end
					tcfo_pkg::OP_DEQ_DOG: begin
						res_d.cls = tcfo_pkg::CLS_DOG;
						if (!dog_flags.empty) begin
							dog_pop      = 1'b1;
							res_d.id     = tcfo_pkg::OUT_ID_W'(dog_head_id);
							res_d.status = tcfo_pkg::ST_OK;
						end
					end
					tcfo_pkg::OP_DEQ_CAT: begin
						res_d.cls = tcfo_pkg::CLS_CAT;
						if (!cat_flags.empty) begin
							cat_pop      = 1'b1;
							res_d.id     = tcfo_pkg::OUT_ID_W'(cat_head_id);
							res_d.status = tcfo_pkg::ST_OK;
						end
					end
					default: begin
						res_d.cls    = tcfo_pkg::CLS_DOG;
						res_d.status = tcfo_pkg::ST_EMPTY;
					end
				endcase
			end
			default: state_d = tcfo_pkg::BK_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tcfo_pkg::BK_FETCH;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cur_q <= cmd;
		if (res_wr)
			res_q[res_wr_ptr_q] <= res_d;
	end

	assign res_empty = (res_cnt_q == 2'd0);
	assign res       = res_q[res_rd_ptr_q];
	assign res_take  = res_pop && !res_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q    <= '0;
			res_wr_ptr_q <= 1'b0;
			res_rd_ptr_q <= 1'b0;
			res_cnt_q    <= 2'd0;
		end else begin
			if (dog_push || cat_push)
				arrival_q <= arrival_q + tcfo_pkg::STAMP_W'(1);
			if (res_wr)
				res_wr_ptr_q <= ~res_wr_ptr_q;
			if (res_take)
				res_rd_ptr_q <= ~res_rd_ptr_q;
			case ({res_wr, res_take})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcfo_pkg::BK_EXEC) |-> (res_cnt_q != 2'(RES_DEPTH)))
		else $error("result buffer has no room for an executing command");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(dog_pop |-> !dog_flags.empty) and (cat_pop |-> !cat_flags.empty))
		else $error("pop from an empty class queue");

	a_one_queue_op: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({dog_push, dog_pop, cat_push, cat_pop}) <= 1)
		else $error("more than one queue touched by one command");

	a_stamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(dog_push || cat_push) |=> $stable(arrival_q))
		else $error("arrival stamp moved without an enqueue");

endmodule

@@ rtl/two_class_fifo_oldest_dequeue_top.sv @@
// Top level of the two-class FIFO with oldest-first dequeue.
`timescale 1ns / 1ps

// Two class queues (dog, cat) sharing one arrival stamp counter.
// Input channel: drive kind and animal_id with push; a word is taken on a
// rising edge with push high and full low. Kinds: enqueue dog, enqueue cat,
// dequeue oldest of either class, dequeue dog, dequeue cat; other codes give
// an empty status and change nothing.
// Result channel: while empty is low the oldest result word sits on out_id,
// out_class and status; it is taken on a rising edge with pop high.
// Every input word yields exactly one result word, in order.
// An accepted word goes through the command queue, the back end's fetch state
// (latch it, read both queue heads from memory) and its execute state (write
// the result word); the back end takes no new word before the last executes.
// A two-entry command queue lets the input side run ahead of the back end, and
// a two-entry result buffer lets the back end keep working while the receiver
// holds pop low. Full rises whenever the command queue holds two words: when
// words arrive every cycle, and for good once the receiver stalls long enough
// to fill the result buffer; input words wait meanwhile.
// Reset (arst_n low) empties both queues, both buffers and zeros the stamp
// counter; queue memory contents are left as they are.

module two_class_fifo_oldest_dequeue_top #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_WIDTH    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tcfo_pkg::KIND_W-1:0]   kind,
	input  logic [tcfo_pkg::OUT_ID_W-1:0] animal_id,
	output logic                          empty,
	input  logic                          pop,
	output logic [tcfo_pkg::OUT_ID_W-1:0] out_id,
	output logic                          out_class,
	output logic [tcfo_pkg::STATUS_W-1:0] status
);

	logic              cmd_valid;
	logic              cmd_pop;
	tcfo_pkg::cmd_t    cmd;
	tcfo_pkg::result_t res;

	// Front end: decode and queue commands
	tcfo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.animal_id (animal_id),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: class queues, oldest-head selection, result buffer
	tcfo_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_empty (empty),
		.res       (res),
		.res_pop   (pop)
	);

	// Split the result word onto its ports
	assign out_id    = res.id;
	assign out_class = res.cls;
	assign status    = res.status;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the two-class FIFO with oldest-first dequeue.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned PEN_DEPTH = 16;
	localparam int unsigned IDLE_CYCLES = 12;
	localparam int unsigned RANDOM_WORDS = 130;
	localparam int unsigned STALE_LAPS = 130;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned HOLD_SPACING = 300;

	// Kind codes the block treats as no-ops
	localparam logic [tcfo_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [tcfo_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	// Flavor of one random segment
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN,
		MIX_ONE_CLASS
	} mix_t;

	typedef struct {
		logic [tcfo_pkg::KIND_W-1:0] kind;
		logic [tcfo_pkg::OUT_ID_W-1:0] id;
	} intake_word_t;

	typedef struct {
		logic [tcfo_pkg::OUT_ID_W-1:0] id;
		logic [tcfo_pkg::STAMP_W-1:0] stamp;
	} pen_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [tcfo_pkg::KIND_W-1:0] kind = tcfo_pkg::KIND_DEQ_ANY;
	logic [tcfo_pkg::OUT_ID_W-1:0] animal_id = '0;
	logic full;
	logic empty;
	logic [tcfo_pkg::OUT_ID_W-1:0] out_id;
	logic out_class;
	logic [tcfo_pkg::STATUS_W-1:0] status;

	// Input words still to be offered, and result words the block owes us
	intake_word_t intake_queue[$];
	tcfo_pkg::result_t owed_results[$];

	// Shadow copy of both class queues and the shared arrival stamp
	pen_entry_t dog_pen[$];
	pen_entry_t cat_pen[$];
	logic [tcfo_pkg::STAMP_W-1:0] arrival_stamp = '0;

	int failures = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int next_hold_at = 150;
	int pattern_age = 0;
	logic [15:0] stall_pattern = 16'hffff;
	intake_word_t next_word;
	tcfo_pkg::result_t owed;

	two_class_fifo_oldest_dequeue_top #(
		.QUEUE_DEPTH(PEN_DEPTH),
		.ID_WIDTH(tcfo_pkg::OUT_ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.animal_id(animal_id),
		.empty(empty),
		.pop(pop),
		.out_id(out_id),
		.out_class(out_class),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one accepted word to the shadow queues and return the word the
	// block must answer with.
	function automatic tcfo_pkg::result_t predict_shelter(
			input logic [tcfo_pkg::KIND_W-1:0] op,
			input logic [tcfo_pkg::OUT_ID_W-1:0] id);
		tcfo_pkg::result_t r;
		pen_entry_t e;
		logic [tcfo_pkg::STAMP_W-1:0] age_gap;
		logic take;
		r.id = '0;
		r.cls = tcfo_pkg::CLS_DOG;
		r.status = tcfo_pkg::ST_EMPTY;
		take = 1'b0;
		case (op) inside
			tcfo_pkg::KIND_ENQ_DOG, tcfo_pkg::KIND_ENQ_CAT: begin
				r.cls = (op == tcfo_pkg::KIND_ENQ_CAT) ? tcfo_pkg::CLS_CAT : tcfo_pkg::CLS_DOG;
				e.id = id;
				e.stamp = arrival_stamp;
				if (r.cls == tcfo_pkg::CLS_CAT && cat_pen.size() < PEN_DEPTH) begin
					cat_pen = {cat_pen, e};
					r.status = tcfo_pkg::ST_OK;
				end else if (r.cls == tcfo_pkg::CLS_DOG && dog_pen.size() < PEN_DEPTH) begin
					dog_pen = {dog_pen, e};
					r.status = tcfo_pkg::ST_OK;
				end else begin
					r.status = tcfo_pkg::ST_FULL;
				end
				// The stamp only advances when an entry really went in
				if (r.status == tcfo_pkg::ST_OK)
					arrival_stamp = arrival_stamp + tcfo_pkg::STAMP_W'(1);
			end
			tcfo_pkg::KIND_DEQ_ANY: begin
				take = 1'b1;
				if (cat_pen.size() == 0) begin
					r.cls = tcfo_pkg::CLS_DOG;
				end else if (dog_pen.size() == 0) begin
					r.cls = tcfo_pkg::CLS_CAT;
				end else begin
					// Modular age compare: dog wins while the cat is less than
					// half the stamp range newer.
					age_gap = cat_pen[0].stamp - dog_pen[0].stamp;
					r.cls = age_gap[tcfo_pkg::STAMP_W-1] ? tcfo_pkg::CLS_CAT
						: tcfo_pkg::CLS_DOG;
				end
			end
			tcfo_pkg::KIND_DEQ_DOG: begin
				take = 1'b1;
				r.cls = tcfo_pkg::CLS_DOG;
			end
			tcfo_pkg::KIND_DEQ_CAT: begin
				take = 1'b1;
				r.cls = tcfo_pkg::CLS_CAT;
			end
			default: begin
			end
		endcase
		if (take) begin
			if (r.cls == tcfo_pkg::CLS_CAT && cat_pen.size() != 0) begin
				e = cat_pen.pop_front();
				r.id = e.id;
				r.status = tcfo_pkg::ST_OK;
			end else if (r.cls == tcfo_pkg::CLS_DOG && dog_pen.size() != 0) begin
				e = dog_pen.pop_front();
				r.id = e.id;
				r.status = tcfo_pkg::ST_OK;
			end
		end
		return r;
	endfunction

	task automatic add_word(input logic [tcfo_pkg::KIND_W-1:0] k,
			input logic [tcfo_pkg::OUT_ID_W-1:0] id);
		intake_word_t w;
		w.kind = k;
		w.id = id;
		intake_queue = {intake_queue, w};
	endtask

	function automatic logic [tcfo_pkg::KIND_W-1:0] any_dequeue();
		case ($urandom_range(2, 0))
			0: return tcfo_pkg::KIND_DEQ_ANY;
			1: return tcfo_pkg::KIND_DEQ_DOG;
			default: return tcfo_pkg::KIND_DEQ_CAT;
		endcase
	endfunction

	function automatic logic [tcfo_pkg::KIND_W-1:0] spare_kind();
		return tcfo_pkg::KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
	endfunction

	function automatic logic [tcfo_pkg::KIND_W-1:0] pick_kind(input mix_t mix, input logic cls);
		int roll;
		roll = $urandom_range(99, 0);
		// A little noise on unused codes in every segment
		if (roll < 4)
			return spare_kind();
		case (mix)
			MIX_FILL:
				return (roll < 80)
					? ($urandom_range(1, 0) ? tcfo_pkg::KIND_ENQ_CAT : tcfo_pkg::KIND_ENQ_DOG)
					: any_dequeue();
			MIX_DRAIN:
				return (roll < 20)
					? ($urandom_range(1, 0) ? tcfo_pkg::KIND_ENQ_CAT : tcfo_pkg::KIND_ENQ_DOG)
					: any_dequeue();
			MIX_ONE_CLASS:
				if (roll < 75)
					return cls ? tcfo_pkg::KIND_ENQ_CAT : tcfo_pkg::KIND_ENQ_DOG;
				else if (roll < 88)
					return cls ? tcfo_pkg::KIND_DEQ_CAT : tcfo_pkg::KIND_DEQ_DOG;
				else
					return tcfo_pkg::KIND_DEQ_ANY;
			default:
				return (roll < 45)
					? ($urandom_range(1, 0) ? tcfo_pkg::KIND_ENQ_CAT : tcfo_pkg::KIND_ENQ_DOG)
					: any_dequeue();
		endcase
	endfunction

	task automatic build_stimulus();
		int made;
		int seg_len;
		mix_t mix;
		logic cls;
		logic stale_done;
		made = 0;
		stale_done = 1'b0;

		// Directed opening: empty dequeues of every flavor, unused codes,
		// extreme identifiers, age ordering across classes.
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_DOG, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_CAT, 16'hffff);
		add_word(KIND_SPARE_LO, 16'h1234);
		add_word(KIND_SPARE_HI, 16'h0000);
		add_word(KIND_SPARE_LO + 3'd1, 16'hffff);
		add_word(tcfo_pkg::KIND_ENQ_DOG, 16'h0000);
		add_word(tcfo_pkg::KIND_ENQ_CAT, 16'hffff);
		add_word(tcfo_pkg::KIND_ENQ_DOG, 16'h0001);
		add_word(tcfo_pkg::KIND_ENQ_CAT, 16'h8000);
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'hffff);
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'h0000);
		add_word(tcfo_pkg::KIND_ENQ_CAT, 16'haaaa);
		add_word(tcfo_pkg::KIND_ENQ_DOG, 16'h5555);
		add_word(tcfo_pkg::KIND_DEQ_DOG, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_ANY, 16'h0000);
		add_word(tcfo_pkg::KIND_DEQ_DOG, 16'hffff);

		while (made < RANDOM_WORDS) begin
			// Midway, park a dog at the head while more than half the stamp
			// range of cats passes through, then let dequeue-any choose.
			if (!stale_done && made >= RANDOM_WORDS / 2) begin
				stale_done = 1'b1;
				repeat (PEN_DEPTH + 2)
					add_word(tcfo_pkg::KIND_DEQ_DOG, tcfo_pkg::OUT_ID_W'($urandom()));
				repeat (PEN_DEPTH + 2)
					add_word(tcfo_pkg::KIND_DEQ_CAT, tcfo_pkg::OUT_ID_W'($urandom()));
				add_word(tcfo_pkg::KIND_ENQ_DOG, tcfo_pkg::OUT_ID_W'($urandom()));
				repeat (STALE_LAPS) begin
					add_word(tcfo_pkg::KIND_ENQ_CAT, tcfo_pkg::OUT_ID_W'($urandom()));
					add_word(tcfo_pkg::KIND_DEQ_CAT, tcfo_pkg::OUT_ID_W'($urandom()));
				end
				add_word(tcfo_pkg::KIND_ENQ_CAT, tcfo_pkg::OUT_ID_W'($urandom()));
				add_word(tcfo_pkg::KIND_DEQ_ANY, tcfo_pkg::OUT_ID_W'($urandom()));
				add_word(tcfo_pkg::KIND_DEQ_ANY, tcfo_pkg::OUT_ID_W'($urandom()));
			end
			mix = mix_t'($urandom_range(MIX_ONE_CLASS, MIX_FILL));
			cls = 1'($urandom_range(1, 0));
			seg_len = $urandom_range(40, 8);
			repeat (seg_len) begin
				add_word(pick_kind(mix, cls), tcfo_pkg::OUT_ID_W'($urandom()));
				made++;
			end
		end
	endtask

	// Driver: offer words in bursts with random gaps; hold a word while full.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				owed_results = {owed_results, predict_shelter(kind, animal_id)};
			if (push && full) begin
				// hold the current word until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (intake_queue.size() != 0) begin
				next_word = intake_queue.pop_front();
				push <= 1'b1;
				kind <= next_word.kind;
				animal_id <= next_word.id;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(24, 1);
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: check each taken result word against the oldest owed one,
	// then choose whether to pop on the next edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result word: out_id %h out_class %b status %0d",
						out_id, out_class, status);
					failures++;
				end else begin
					owed = owed_results.pop_front();
					results_seen++;
					if (out_id !== owed.id) begin
						$error("out_id mismatch: expected %h, actual %h", owed.id, out_id);
						failures++;
					end
					if (out_class !== owed.cls) begin
						$error("out_class mismatch: expected %b, actual %b",
							owed.cls, out_class);
						failures++;
					end
					if (status !== owed.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							owed.status, status);
						failures++;
					end
				end
			end

			// Long hold-off now and then so the block backs up and raises full
			if (hold_left == 0 && results_seen >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at += HOLD_SPACING;
			end

			// Reload the stall pattern when pattern_age wraps: none, sparse, even, dense
			if (pattern_age == 0) begin
				case ($urandom_range(3, 0))
					0: stall_pattern = 16'hffff;
					1: stall_pattern = 16'($urandom() | $urandom());
					2: stall_pattern = 16'($urandom());
					default: stall_pattern = 16'($urandom() & $urandom());
				endcase
			end
			pattern_age = (pattern_age + 1) % 64;

			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= stall_pattern[0];
			end
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	initial begin
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything offered, taken and answered
		@(negedge clk);
		while (intake_queue.size() != 0 || push || owed_results.size() != 0)
			@(negedge clk);
		// Let any stray word surface before judging
		repeat (IDLE_CYCLES) @(negedge clk);

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tcfo_pkg.sv
rtl/tcfo_front.sv
rtl/tcfo_class_fifo.sv
rtl/tcfo_back.sv
rtl/two_class_fifo_oldest_dequeue_top.sv
test/testbench.sv
